// ===== design/clipped_tile_blit_rows_top_macros.svh =====
// Assertion macros for the tile blit row block.
// Every assertion samples on clk and is disabled while rst_n is low.
`ifndef CLIPPED_TILE_BLIT_ROWS_TOP_MACROS_SVH
`define CLIPPED_TILE_BLIT_ROWS_TOP_MACROS_SVH

// Same-cycle implication
`define CBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbr assertion failed");

// Next-cycle implication
`define CBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbr assertion failed");

`endif

// ===== design/cbr_pkg.sv =====
package cbr_pkg;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int TW_W     = 9;
  localparam int TH_W     = 7;
  localparam int POS_W    = 16;
  localparam int SURF_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Tile size limits
  localparam logic [TW_W-1:0] MAX_TILE_WIDTH  = 9'd256;
  localparam logic [TH_W-1:0] MAX_TILE_HEIGHT = 7'd64;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_BASE   = 2'd0,
    CFG_SURFACE_WIDTH  = 2'd1,
    CFG_SURFACE_HEIGHT = 2'd2
  } cfg_idx_t;

  // One clipped command: start addresses, row length, row count, pitches
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [TW_W-1:0]   len;
    logic [TH_W-1:0]   rows;
    logic [SURF_W-1:0] dpitch;
    logic [TW_W-1:0]   spitch;
  } desc_t;

endpackage

// ===== design/cbr_front.sv =====
module cbr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbr_pkg::ADDR_W-1:0]     in_tile_base,
  input  logic [cbr_pkg::TW_W-1:0]       in_tile_width,
  input  logic [cbr_pkg::TH_W-1:0]       in_tile_height,
  input  logic signed [cbr_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [cbr_pkg::POS_W-1:0] in_pos_y,
  output logic                           q_push,
  output cbr_pkg::desc_t                 q_desc,
  input  logic                           q_full
);
  import cbr_pkg::*;

  // Surface registers
  logic [ADDR_W-1:0] base_r;
  logic [SURF_W-1:0] sw_r, sh_r;

  // Clip stage registers
  logic              a_vld_r, a_vld_nxt;
  logic              a_vis_r;
  logic [ADDR_W-1:0] a_tbase_r;
  logic [SURF_W-1:0] a_xr_r, a_yr_r;
  logic [7:0]        a_sx_r;
  logic [5:0]        a_sy_r;
  logic [TW_W-1:0]   a_tw_r, a_len_r;
  logic [TH_W-1:0]   a_rows_r;

  logic              in_acc, a_adv;
  logic [TW_W-1:0]   tw_s;
  logic [TH_W-1:0]   th_s;
  logic signed [17:0] x_e, y_e, tw_e, th_e, sw_e, sh_e;
  logic signed [17:0] cw1, ch1, xr, yr, cw, ch;
  logic              vis;
  logic [25:0]       dprod;
  logic [14:0]       sprod;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      sw_r   <= 13'd640;
      sh_r   <= 13'd480;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SURFACE_BASE:   base_r <= cfg_wdata;
        CFG_SURFACE_WIDTH:  sw_r   <= cfg_wdata[SURF_W-1:0];
        CFG_SURFACE_HEIGHT: sh_r   <= cfg_wdata[SURF_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the tile size
  assign tw_s = (in_tile_width > MAX_TILE_WIDTH) ? MAX_TILE_WIDTH : in_tile_width;
  assign th_s = (in_tile_height > MAX_TILE_HEIGHT) ? MAX_TILE_HEIGHT : in_tile_height;

  assign x_e  = 18'(in_pos_x);
  assign y_e  = 18'(in_pos_y);
  assign tw_e = signed'({9'd0, tw_s});
  assign th_e = signed'({11'd0, th_s});
  assign sw_e = signed'({5'd0, sw_r});
  assign sh_e = signed'({5'd0, sh_r});

  // Clip left and top, then right and bottom
  always_comb begin
    cw1 = in_pos_x[POS_W-1] ? (tw_e + x_e) : tw_e;
    ch1 = in_pos_y[POS_W-1] ? (th_e + y_e) : th_e;
    xr  = in_pos_x[POS_W-1] ? 18'sd0 : x_e;
    yr  = in_pos_y[POS_W-1] ? 18'sd0 : y_e;
    cw  = (xr + cw1 > sw_e) ? (sw_e - xr) : cw1;
    ch  = (yr + ch1 > sh_e) ? (sh_e - yr) : ch1;
    vis = (cw > 18'sd0) && (ch > 18'sd0);
  end

  // Advance the clip stage when the queue takes it or it is dropped
  assign a_adv    = !a_vis_r || !q_full;
  assign in_stall = a_vld_r && !a_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_acc)
      a_vld_nxt = 1'b1;
    else if (a_vld_r && a_adv)
      a_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  // Hold clipped geometry; offsets fit their widths whenever visible
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_vis_r   <= vis;
      a_tbase_r <= in_tile_base;
      a_xr_r    <= xr[SURF_W-1:0];
      a_yr_r    <= yr[SURF_W-1:0];
      a_sx_r    <= in_pos_x[POS_W-1] ? 8'(-x_e) : 8'd0;
      a_sy_r    <= in_pos_y[POS_W-1] ? 6'(-y_e) : 6'd0;
      a_tw_r    <= tw_s;
      a_len_r   <= cw[TW_W-1:0];
      a_rows_r  <= ch[TH_W-1:0];
    end
  end

  // Form start addresses and push the command
  assign dprod = {13'd0, a_yr_r} * {13'd0, sw_r};
  assign sprod = {9'd0, a_sy_r} * {6'd0, a_tw_r};

  always_comb begin
    q_desc.dest   = base_r + 32'(dprod) + 32'(a_xr_r);
    q_desc.src    = a_tbase_r + 32'(sprod) + 32'(a_sx_r);
    q_desc.len    = a_len_r;
    q_desc.rows   = a_rows_r;
    q_desc.dpitch = sw_r;
    q_desc.spitch = a_tw_r;
  end

  assign q_push = a_vld_r && a_vis_r && !q_full;

endmodule

// ===== design/cbr_queue.sv =====
module cbr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbr_pkg::desc_t wr_desc,
  output logic           full,
  input  logic           pop,
  output cbr_pkg::desc_t rd_desc,
  output logic           nempty
);
  import cbr_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign nempty  = (cnt_r != '0);
  assign rd_desc = mem_r[rp_r];

  // Advance pointers and count
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop)
      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push)
      mem_r[wp_r] <= wr_desc;
  end

endmodule

// ===== design/cbr_back.sv =====
module cbr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbr_pkg::desc_t             q_desc,
  input  logic                       q_nempty,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cbr_pkg::ADDR_W-1:0] out_dest_addr,
  output logic [cbr_pkg::ADDR_W-1:0] out_src_addr,
  output logic [cbr_pkg::TW_W-1:0]   out_row_len,
  output logic                       out_last_row
);
  import cbr_pkg::*;

  logic              act_r, act_nxt;
  logic [ADDR_W-1:0] dest_r, dest_nxt, src_r, src_nxt;
  logic [TW_W-1:0]   len_r, len_nxt;
  logic [TH_W-1:0]   rows_r, rows_nxt;
  logic [SURF_W-1:0] dpitch_r, dpitch_nxt;
  logic [TW_W-1:0]   spitch_r, spitch_nxt;
  logic              out_acc, last;

  assign last    = (rows_r == TH_W'(1));
  assign out_acc = act_r && !out_stall;
  assign q_pop   = q_nempty && (!act_r || (out_acc && last));

  // Walk rows: step addresses on each taken request, load the next command
  always_comb begin
    act_nxt    = act_r;
    dest_nxt   = dest_r;
    src_nxt    = src_r;
    len_nxt    = len_r;
    rows_nxt   = rows_r;
    dpitch_nxt = dpitch_r;
    spitch_nxt = spitch_r;
    priority if (q_pop) begin
      act_nxt    = 1'b1;
      dest_nxt   = q_desc.dest;
      src_nxt    = q_desc.src;
      len_nxt    = q_desc.len;
      rows_nxt   = q_desc.rows;
      dpitch_nxt = q_desc.dpitch;
      spitch_nxt = q_desc.spitch;
    end else if (out_acc && last) begin
      act_nxt = 1'b0;
    end else if (out_acc) begin
      dest_nxt = dest_r + 32'(dpitch_r);
      src_nxt  = src_r + 32'(spitch_r);
      rows_nxt = rows_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r   <= dest_nxt;
    src_r    <= src_nxt;
    len_r    <= len_nxt;
    rows_r   <= rows_nxt;
    dpitch_r <= dpitch_nxt;
    spitch_r <= spitch_nxt;
  end

  assign out_valid     = act_r;
  assign out_dest_addr = dest_r;
  assign out_src_addr  = src_r;
  assign out_row_len   = len_r;
  assign out_last_row  = last;

endmodule

// ===== design/clipped_tile_blit_rows_top.sv =====
// Clipped tile blitter, row descriptor generator.
// Input channel (in_*): one draw command per request: tile base, width, height
// and signed position. Output channel (out_*): one row-copy request per visible
// row, top row first, out_last_row set on the final row of a command.
// Configuration (cfg_*): surface base, width and height, to be written only while idle.
// The block does not enforce this. The first row of a command is offered once it
// has passed the clip stage, the command queue and the row walker registers.
// Throughput: the row walker gives one row per cycle while out_stall is low, up to
// 64 visible rows per command. The next command's first row, if queued, follows its
// predecessor's last row without a gap. A fully clipped command is dropped in the
// clip stage and gives no rows.
// The clip stage keeps taking commands into a 4-entry queue while the output
// is stalled; in_stall rises only when that queue is full.
// A stalled output request holds its values until taken.
// Reset: synchronous, active low; clears the queue and the row walker, and
// sets the surface to base 0, 640 x 480.
`include "clipped_tile_blit_rows_top_macros.svh"
module clipped_tile_blit_rows_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbr_pkg::ADDR_W-1:0]     in_tile_base,
  input  logic [cbr_pkg::TW_W-1:0]       in_tile_width,
  input  logic [cbr_pkg::TH_W-1:0]       in_tile_height,
  input  logic signed [cbr_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [cbr_pkg::POS_W-1:0] in_pos_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbr_pkg::ADDR_W-1:0]     out_dest_addr,
  output logic [cbr_pkg::ADDR_W-1:0]     out_src_addr,
  output logic [cbr_pkg::TW_W-1:0]       out_row_len,
  output logic                           out_last_row
);
  import cbr_pkg::*;

  logic  q_push, q_full, q_pop, q_nempty;
  desc_t q_wr_desc, q_rd_desc;

  cbr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tile_base   (in_tile_base),
    .in_tile_width  (in_tile_width),
    .in_tile_height (in_tile_height),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .q_push         (q_push),
    .q_desc         (q_wr_desc),
    .q_full         (q_full)
  );

  cbr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_desc (q_wr_desc),
    .full    (q_full),
    .pop     (q_pop),
    .rd_desc (q_rd_desc),
    .nempty  (q_nempty)
  );

  cbr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_desc        (q_rd_desc),
    .q_nempty      (q_nempty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dest_addr (out_dest_addr),
    .out_src_addr  (out_src_addr),
    .out_row_len   (out_row_len),
    .out_last_row  (out_last_row)
  );

  // Queue never takes a command while full, never pops while empty
  `CBR_ASSERT_IMP(a_q_no_overflow, q_push, !q_full)
  `CBR_ASSERT_IMP(a_q_no_underflow, q_pop, q_nempty)
  // A taken row that is not last is followed by another row of equal length
  `CBR_ASSERT_NEXT(a_row_continues, out_valid && !out_stall && !out_last_row, out_valid && out_row_len == $past(out_row_len))
  // Every row copies at least one word
  `CBR_ASSERT_IMP(a_row_len_nz, out_valid, out_row_len != 9'd0)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cbr_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int STUCK_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int TAIL_CYCLES = 16;
  localparam int NUM_PHASES = 6;
  localparam int NUM_DIRECTED = 20;
  localparam int PRINT_CAP = 60;
  // row count marker: work the rows out from the clip predictor
  localparam int PREDICTED = -1;

  typedef struct {
    logic [ADDR_W-1:0]       tile_base;
    logic [TW_W-1:0]         tile_width;
    logic [TH_W-1:0]         tile_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } blit_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [TW_W-1:0]   row_len;
    logic              last_row;
  } row_desc_t;

  // one directed command; n_rows is 0 or 1 when the row is typed in
  typedef struct {
    logic [ADDR_W-1:0]       tile_base;
    logic [TW_W-1:0]         tile_width;
    logic [TH_W-1:0]         tile_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    int                      n_rows;
    logic [ADDR_W-1:0]       dest_addr;
    logic [ADDR_W-1:0]       src_addr;
    logic [TW_W-1:0]         row_len;
  } directed_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [SURF_W-1:0] width;
    logic [SURF_W-1:0] height;
    int                n_cmds;
    bit                steady;
  } surface_phase_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [ADDR_W-1:0]       in_tile_base;
  logic [TW_W-1:0]         in_tile_width;
  logic [TH_W-1:0]         in_tile_height;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic                    out_valid;
  logic                    out_stall;
  logic [ADDR_W-1:0]       out_dest_addr;
  logic [ADDR_W-1:0]       out_src_addr;
  logic [TW_W-1:0]         out_row_len;
  logic                    out_last_row;

  // surface registers as the predictor sees them
  logic [ADDR_W-1:0] surf_base;
  logic [SURF_W-1:0] surf_width;
  logic [SURF_W-1:0] surf_height;

  row_desc_t     pending_rows[$];
  directed_cmd_t directed_tbl[NUM_DIRECTED];
  surface_phase_t phase_tbl[NUM_PHASES];

  int   mismatches = 0;
  int   stuck_cycles = 0;
  bit   req_taken = 1'b0;
  bit   steady = 1'b0;
  // typed expectation of the request on the bus
  int   cur_n_rows = PREDICTED;
  row_desc_t cur_row;

  clipped_tile_blit_rows_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tile_base   (in_tile_base),
    .in_tile_width  (in_tile_width),
    .in_tile_height (in_tile_height),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_addr  (out_dest_addr),
    .out_src_addr   (out_src_addr),
    .out_row_len    (out_row_len),
    .out_last_row   (out_last_row)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Clip one command against the surface and queue its row descriptors
  function automatic void clip_tile_rows(input blit_cmd_t c);
    longint tw, th, x, y, sx, sy, cw, ch, sw, sh;
    logic [ADDR_W-1:0] dest, src;
    row_desc_t r;
    tw = c.tile_width;
    th = c.tile_height;
    if (tw > longint'(MAX_TILE_WIDTH)) tw = longint'(MAX_TILE_WIDTH);
    if (th > longint'(MAX_TILE_HEIGHT)) th = longint'(MAX_TILE_HEIGHT);
    x = c.pos_x;
    y = c.pos_y;
    sw = surf_width;
    sh = surf_height;
    sx = 0;
    sy = 0;
    cw = tw;
    ch = th;
    if (x < 0) begin
      sx = -x;
      cw = cw + x;
      x = 0;
    end
    if (y < 0) begin
      sy = -y;
      ch = ch + y;
      y = 0;
    end
    if (x + cw > sw) cw = sw - x;
    if (y + ch > sh) ch = sh - y;
    if (cw <= 0 || ch <= 0) return;
    dest = surf_base + ADDR_W'(y * sw + x);
    src = c.tile_base + ADDR_W'(sy * tw + sx);
    for (longint i = ch; i > 0; i--) begin
      r.dest_addr = dest;
      r.src_addr = src;
      r.row_len = cw[TW_W-1:0];
      r.last_row = (i == 1);
      pending_rows.push_back(r);
      dest = dest + ADDR_W'(sw);
      src = src + ADDR_W'(tw);
    end
  endfunction

  // Take requests on both channels at the rising edge
  always @(posedge clk) begin
    blit_cmd_t c;
    row_desc_t e;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken) begin
      if (cur_n_rows == PREDICTED) begin
        c.tile_base = in_tile_base;
        c.tile_width = in_tile_width;
        c.tile_height = in_tile_height;
        c.pos_x = in_pos_x;
        c.pos_y = in_pos_y;
        clip_tile_rows(c);
      end else if (cur_n_rows == 1) begin
        pending_rows.push_back(cur_row);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row dest=%h src=%h len=%0d last=%b",
                                  out_dest_addr, out_src_addr, out_row_len, out_last_row));
      end else begin
        e = pending_rows.pop_front();
        if (out_dest_addr !== e.dest_addr)
          report_mismatch($sformatf("dest_addr %h, want %h", out_dest_addr, e.dest_addr));
        if (out_src_addr !== e.src_addr)
          report_mismatch($sformatf("src_addr %h, want %h", out_src_addr, e.src_addr));
        if (out_row_len !== e.row_len)
          report_mismatch($sformatf("row_len %0d, want %0d", out_row_len, e.row_len));
        if (out_last_row !== e.last_row)
          report_mismatch($sformatf("last_row %b, want %b", out_last_row, e.last_row));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random backpressure on the row channel
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 23);
  end

  // Drive one command and hold it until it is taken
  task automatic send_cmd(input blit_cmd_t c, input int n_rows, input row_desc_t row);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tile_base <= c.tile_base;
    in_tile_width <= c.tile_width;
    in_tile_height <= c.tile_height;
    in_pos_x <= c.pos_x;
    in_pos_y <= c.pos_y;
    cur_n_rows = n_rows;
    cur_row = row;
    do @(negedge clk); while (!req_taken);
  endtask

  // Drop valid and let every queued command finish
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_surface(input surface_phase_t p);
    write_reg(CFG_SURFACE_BASE, p.base);
    write_reg(CFG_SURFACE_WIDTH, CFG_DATA_W'(p.width));
    write_reg(CFG_SURFACE_HEIGHT, CFG_DATA_W'(p.height));
    cfg_wr_en <= 1'b0;
    surf_base = p.base;
    surf_width = p.width;
    surf_height = p.height;
  endtask

  // Place a tile edge so that it mostly straddles or touches the surface
  function automatic logic signed [POS_W-1:0] place_edge(input int span, input int extent);
    int lo, hi, v;
    if ($urandom_range(99) < 15) return POS_W'($urandom);
    lo = -extent - 2;
    hi = span + 2;
    v = lo + int'($urandom_range(0, hi - lo));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return POS_W'(v);
  endfunction

  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    int pick;
    c.tile_base = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) c.tile_width = TW_W'($urandom_range(1, 32));
    else if (pick < 85) c.tile_width = TW_W'($urandom_range(33, 256));
    else if (pick < 95) c.tile_width = TW_W'($urandom_range(257, 511));
    else c.tile_width = '0;
    pick = $urandom_range(99);
    if (pick < 70) c.tile_height = TH_W'($urandom_range(1, 16));
    else if (pick < 90) c.tile_height = TH_W'($urandom_range(17, 64));
    else if (pick < 97) c.tile_height = TH_W'($urandom_range(65, 127));
    else c.tile_height = '0;
    c.pos_x = place_edge(int'(surf_width), int'(c.tile_width));
    c.pos_y = place_edge(int'(surf_height), int'(c.tile_height));
    return c;
  endfunction

  initial begin
    blit_cmd_t c;
    row_desc_t r;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_tile_base = '0;
    in_tile_width = '0;
    in_tile_height = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    out_stall = 1'b0;
    surf_base = '0;
    surf_width = 13'd640;
    surf_height = 13'd480;

    // base, width, height, x, y, rows, dest, src, len (surface 640 x 480 at 0)
    directed_tbl = '{
      '{32'h0000_1000, 1, 1, 0, 0, 1, 32'h0, 32'h0000_1000, 1},
      '{32'hFFFF_FFFF, 1, 1, 639, 479, 1, 32'h0004_AFFF, 32'hFFFF_FFFF, 1},
      '{32'h0000_0040, 1, 1, 640, 0, 0, 32'h0, 32'h0, 0},
      '{32'h0000_0040, 1, 1, 0, 480, 0, 32'h0, 32'h0, 0},
      '{32'h1234_5678, 0, 5, 10, 10, 0, 32'h0, 32'h0, 0},
      '{32'h1234_5678, 5, 0, 10, 10, 0, 32'h0, 32'h0, 0},
      '{32'h0000_0000, 256, 64, -32768, 0, 0, 32'h0, 32'h0, 0},
      '{32'h0000_0000, 256, 64, 32767, 32767, 0, 32'h0, 32'h0, 0},
      '{32'hABCD_0000, 256, 64, 0, 0, PREDICTED, 32'h0, 32'h0, 0},
      '{32'hFFFF_FF00, 511, 127, -10, -5, PREDICTED, 32'h0, 32'h0, 0},
      '{32'h0000_2000, 300, 1, 0, 0, 1, 32'h0, 32'h0000_2000, 256},
      '{32'h0000_0100, 8, 1, -3, 0, 1, 32'h0, 32'h0000_0103, 5},
      '{32'h0000_0200, 8, 1, 636, 0, 1, 32'h0000_027C, 32'h0000_0200, 4},
      '{32'h0000_0300, 8, 8, -8, 0, 0, 32'h0, 32'h0, 0},
      '{32'h0000_0400, 8, 8, -7, -7, PREDICTED, 32'h0, 32'h0, 0},
      '{32'h5555_AAAA, 16, 16, 632, 472, PREDICTED, 32'h0, 32'h0, 0},
      '{32'hAAAA_5555, 256, 64, 400, -63, PREDICTED, 32'h0, 32'h0, 0},
      '{32'h7FFF_FFFF, 255, 63, 100, 200, PREDICTED, 32'h0, 32'h0, 0},
      '{32'h8000_0000, 1, 64, 0, 470, PREDICTED, 32'h0, 32'h0, 0},
      '{32'hFFFF_FFFF, 511, 127, -255, -63, PREDICTED, 32'h0, 32'h0, 0}
    };

    // base, width, height, commands, no idling
    phase_tbl = '{
      '{$urandom, 13'd1, 13'd1, 80, 1'b0},
      '{32'hFFFF_FFF0, 13'd4096, 13'd4096, 80, 1'b1},
      '{$urandom, SURF_W'($urandom_range(1, 1024)), SURF_W'($urandom_range(1, 512)),
        80, 1'b0},
      '{32'h0, 13'd0, 13'd300, 20, 1'b0},
      '{$urandom, 13'h1FFF, 13'h1FFF, 80, 1'b0},
      '{$urandom, SURF_W'($urandom), SURF_W'($urandom), 90, 1'b0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table under the reset surface
    foreach (directed_tbl[i]) begin
      c.tile_base = directed_tbl[i].tile_base;
      c.tile_width = directed_tbl[i].tile_width;
      c.tile_height = directed_tbl[i].tile_height;
      c.pos_x = directed_tbl[i].pos_x;
      c.pos_y = directed_tbl[i].pos_y;
      r.dest_addr = directed_tbl[i].dest_addr;
      r.src_addr = directed_tbl[i].src_addr;
      r.row_len = directed_tbl[i].row_len;
      r.last_row = 1'b1;
      send_cmd(c, directed_tbl[i].n_rows, r);
    end

    // Random commands, one surface setting per phase
    foreach (phase_tbl[p]) begin
      wait_idle(DRAIN_CYCLES);
      set_surface(phase_tbl[p]);
      steady = phase_tbl[p].steady;
      for (int n = 0; n < phase_tbl[p].n_cmds; n++) begin
        send_cmd(random_cmd(), PREDICTED, r);
      end
    end
    steady = 1'b0;

    wait_idle(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
